>>> src/ate_pkg.sv
// Shared types, constants and the arctangent table of the tilt angle engine.
`default_nettype none
package ate_pkg;

   localparam int BURST_BYTES = 14;
   localparam int WORD_COUNT  = 7;
   localparam int COUNT_W     = 4;
   localparam int ATAN_LEN    = 24;
   localparam int STEP_W      = 5;
   localparam int SQRT_STEPS  = 16;
   localparam int CORDIC_W    = 36;
   localparam int PRESCALE    = 16;

   // word positions inside a burst
   localparam int AX_IDX   = 0;
   localparam int AY_IDX   = 1;
   localparam int AZ_IDX   = 2;
   localparam int TEMP_IDX = 3;
   localparam int GX_IDX   = 4;
   localparam int GY_IDX   = 5;
   localparam int GZ_IDX   = 6;

   localparam logic signed [CORDIC_W-1:0] PI_Q30      = 36'sd3373259426;
   localparam logic signed [30:0]         DEG_PER_RAD = 31'sd961263669;

   typedef logic [WORD_COUNT-1:0][15:0] word_set_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_SQ_A,
      OP_SQ_B,
      OP_SQRT,
      OP_INIT,
      OP_ITER,
      OP_MUL_LO,
      OP_MUL_HI,
      OP_ROUND
   } dp_op_type;

   typedef struct packed {
      dp_op_type         op;
      logic              pitch_sel;
      logic [STEP_W-1:0] step;
   } dp_cmd_type;

   // atan(2^-i) in Q30, truncated
   function automatic logic [29:0] atan_q30(input logic [STEP_W-1:0] idx);
      logic [29:0] v;
      case (idx)
         5'd0:  v = 30'h3243F6A8;
         5'd1:  v = 30'h1DAC6705;
         5'd2:  v = 30'h0FADBAFC;
         5'd3:  v = 30'h07F56EA6;
         5'd4:  v = 30'h03FEAB76;
         5'd5:  v = 30'h01FFD55B;
         5'd6:  v = 30'h00FFFAAA;
         5'd7:  v = 30'h007FFF55;
         5'd8:  v = 30'h003FFFEA;
         5'd9:  v = 30'h001FFFFD;
         5'd10: v = 30'h000FFFFF;
         5'd11: v = 30'h0007FFFF;
         5'd12: v = 30'h0003FFFF;
         5'd13: v = 30'h0001FFFF;
         5'd14: v = 30'h0000FFFF;
         5'd15: v = 30'h00007FFF;
         5'd16: v = 30'h00003FFF;
         5'd17: v = 30'h00001FFF;
         5'd18: v = 30'h00000FFF;
         5'd19: v = 30'h000007FF;
         5'd20: v = 30'h000003FF;
         5'd21: v = 30'h000001FF;
         5'd22: v = 30'h000000FF;
         5'd23: v = 30'h0000007F;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

>>> src/ate_if.sv
// Request and response channel interfaces of the tilt angle engine.
`default_nettype none
interface ate_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] burst_byte;
   logic       burst_start;

   modport source (output valid, output burst_byte, output burst_start, input ready);
   modport sink   (input valid, input burst_byte, input burst_start, output ready);
endinterface

interface ate_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_y;
   logic signed [15:0] accel_z;
   logic signed [15:0] temperature_raw;
   logic signed [15:0] gyro_x;
   logic signed [15:0] gyro_y;
   logic signed [15:0] gyro_z;
   logic signed [15:0] roll_angle;
   logic signed [14:0] pitch_angle;

   modport source (output valid, output accel_x, output accel_y, output accel_z,
                   output temperature_raw, output gyro_x, output gyro_y, output gyro_z,
                   output roll_angle, output pitch_angle, input ready);
   modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                   input temperature_raw, input gyro_x, input gyro_y, input gyro_z,
                   input roll_angle, input pitch_angle, output ready);
endinterface
`default_nettype wire

>>> src/accel_tilt_angle_engine_core.sv
// Top level of the tilt angle engine: channels, sensor register, output register.
//
// Usage: raw bytes of a 14-byte sensor burst arrive one per request on req_if,
// high byte of each word first; burst_start marks the first byte and drops any
// partial burst. Bytes without an open burst, and all bytes while the
// sensor_present register (csr_we / csr_wdata) is 0, are taken and dropped.
// After the 14th byte one response on rsp_if carries the seven words and the
// roll and pitch angles in degrees with ANGLE_FRAC_BITS fraction bits.
// Throughput: one byte per cycle while req_if.ready is high. The angle work runs
// on the shared CORDIC unit: a 16-step root, then one CORDIC pass and a two-part
// multiply per angle.
// The words are snapshot at burst end, so the next burst streams in meanwhile;
// only its 14th byte is held off (ready low) until the angle work is done.
// A finished response sits in the output register; while rsp_if.ready is low
// the sequencer waits and the next 14th byte stays stalled.
// Reset (synchronous, active high) clears the sensor register, closes any
// burst, idles the sequencer and drops a pending response.
`default_nettype none
module accel_tilt_angle_engine_core #(
   parameter int ANGLE_FRAC_BITS = 7,
   parameter int CORDIC_STEPS    = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   ate_req_if.sink    req_if,
   ate_rsp_if.source  rsp_if,
   input  wire logic  csr_we,
   input  wire logic  csr_wdata
);

   logic                  present_ff;
   logic                  rsp_valid_ff;
   ate_pkg::word_set_type rsp_words_ff;
   logic [15:0]           rsp_roll_ff;
   logic [14:0]           rsp_pitch_ff;

   logic                  req_take;
   logic                  burst_done;
   logic                  near_full;
   logic                  busy;
   logic                  load;
   logic                  out_free;
   ate_pkg::word_set_type burst_words;
   ate_pkg::word_set_type dp_words;
   logic [15:0]           dp_roll;
   logic [14:0]           dp_pitch;
   ate_pkg::dp_cmd_type   cmd;

   // hold off only a request that could close a burst while the angle unit is busy
   assign req_if.ready = !(busy && near_full);
   assign req_take     = req_if.valid && req_if.ready && present_ff;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= 1'b0;
      end else if (csr_we) begin
         present_ff <= csr_wdata;
      end
   end

   ate_collect u_collect (
      .clock      (clock),
      .reset      (reset),
      .byte_take  (req_take),
      .byte_in    (req_if.burst_byte),
      .start_in   (req_if.burst_start),
      .burst_done (burst_done),
      .near_full  (near_full),
      .words      (burst_words)
   );

   ate_ctrl #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .launch   (burst_done),
      .out_free (out_free),
      .cmd      (cmd),
      .busy     (busy),
      .load     (load)
   );

   ate_datapath #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_datapath (
      .clock     (clock),
      .cmd       (cmd),
      .words_in  (burst_words),
      .words_out (dp_words),
      .roll_out  (dp_roll),
      .pitch_out (dp_pitch)
   );

   // output register: advance on load, drop valid once the response is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_words_ff <= dp_words;
         rsp_roll_ff  <= dp_roll;
         rsp_pitch_ff <= dp_pitch;
      end
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.accel_x         = signed'(rsp_words_ff[ate_pkg::AX_IDX]);
   assign rsp_if.accel_y         = signed'(rsp_words_ff[ate_pkg::AY_IDX]);
   assign rsp_if.accel_z         = signed'(rsp_words_ff[ate_pkg::AZ_IDX]);
   assign rsp_if.temperature_raw = signed'(rsp_words_ff[ate_pkg::TEMP_IDX]);
   assign rsp_if.gyro_x          = signed'(rsp_words_ff[ate_pkg::GX_IDX]);
   assign rsp_if.gyro_y          = signed'(rsp_words_ff[ate_pkg::GY_IDX]);
   assign rsp_if.gyro_z          = signed'(rsp_words_ff[ate_pkg::GZ_IDX]);
   assign rsp_if.roll_angle      = signed'(rsp_roll_ff);
   assign rsp_if.pitch_angle     = signed'(rsp_pitch_ff);

endmodule
`default_nettype wire

>>> src/ate_collect.sv
// Burst byte collector: byte store, byte count and burst framing.
`default_nettype none
module ate_collect (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 byte_take,
   input  wire logic [7:0]           byte_in,
   input  wire logic                 start_in,
   output      logic                 burst_done,
   output      logic                 near_full,
   output      ate_pkg::word_set_type words
);

   logic [7:0]                  store_ff [ate_pkg::BURST_BYTES];
   logic [ate_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                        open_ff, open_in;
   logic                        done_ff, done_in;
   logic                        eff_open;
   logic [ate_pkg::COUNT_W-1:0] eff_count;
   logic                        write_en;
   logic                        last_byte;

   localparam logic [ate_pkg::COUNT_W-1:0] LAST_POS =
      ate_pkg::COUNT_W'(ate_pkg::BURST_BYTES - 1);

   always_comb begin
      eff_open  = start_in | open_ff;
      eff_count = start_in ? '0 : count_ff;
      write_en  = byte_take & eff_open;
      last_byte = eff_count == LAST_POS;
      count_in  = count_ff;
      open_in   = open_ff;
      done_in   = 1'b0;
      if (write_en) begin
         count_in = eff_count + 1'b1;
         open_in  = !last_byte;
         done_in  = last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         open_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         open_ff  <= open_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (write_en) begin
         store_ff[eff_count] <= byte_in;
      end
   end

   always_comb begin
      for (int k = 0; k < ate_pkg::WORD_COUNT; k++) begin
         words[k] = {store_ff[2*k], store_ff[2*k+1]};
      end
   end

   assign burst_done = done_ff;
   assign near_full  = open_ff && (count_ff == LAST_POS);

endmodule
`default_nettype wire

>>> src/ate_ctrl.sv
// Sequencer for the angle datapath: square, root, two CORDIC passes, scaling.
`default_nettype none
module ate_ctrl #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              launch,
   input  wire logic              out_free,
   output      ate_pkg::dp_cmd_type cmd,
   output      logic              busy,
   output      logic              load
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQ_A, ST_SQ_B, ST_SQRT, ST_INIT, ST_ITER,
      ST_MUL_LO, ST_MUL_HI, ST_ROUND, ST_DONE
   } state_type;

   localparam logic [ate_pkg::STEP_W-1:0] LAST_ITER =
      ate_pkg::STEP_W'(CORDIC_STEPS - 1);
   localparam logic [ate_pkg::STEP_W-1:0] SQRT_LAST =
      ate_pkg::STEP_W'(ate_pkg::SQRT_STEPS - 1);

   state_type                   state_ff;
   logic [ate_pkg::STEP_W-1:0]  step_ff;
   logic                        pitch_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         pitch_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (launch) begin
                  state_ff <= ST_SQ_A;
               end
            end
            ST_SQ_A: state_ff <= ST_SQ_B;
            ST_SQ_B: begin
               state_ff <= ST_SQRT;
               step_ff  <= '0;
            end
            ST_SQRT: begin
               if (step_ff == SQRT_LAST) begin
                  state_ff <= ST_INIT;
                  pitch_ff <= 1'b0;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_INIT: begin
               state_ff <= ST_ITER;
               step_ff  <= '0;
            end
            ST_ITER: begin
               if (step_ff == LAST_ITER) begin
                  state_ff <= ST_MUL_LO;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_MUL_LO: state_ff <= ST_MUL_HI;
            ST_MUL_HI: state_ff <= ST_ROUND;
            ST_ROUND: begin
               if (pitch_ff) begin
                  state_ff <= ST_DONE;
               end else begin
                  pitch_ff <= 1'b1;
                  state_ff <= ST_INIT;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_comb begin
      cmd.step      = step_ff;
      cmd.pitch_sel = pitch_ff;
      case (state_ff)
         ST_IDLE:   cmd.op = launch ? ate_pkg::OP_CAPTURE : ate_pkg::OP_NONE;
         ST_SQ_A:   cmd.op = ate_pkg::OP_SQ_A;
         ST_SQ_B:   cmd.op = ate_pkg::OP_SQ_B;
         ST_SQRT:   cmd.op = ate_pkg::OP_SQRT;
         ST_INIT:   cmd.op = ate_pkg::OP_INIT;
         ST_ITER:   cmd.op = ate_pkg::OP_ITER;
         ST_MUL_LO: cmd.op = ate_pkg::OP_MUL_LO;
         ST_MUL_HI: cmd.op = ate_pkg::OP_MUL_HI;
         ST_ROUND:  cmd.op = ate_pkg::OP_ROUND;
         default:   cmd.op = ate_pkg::OP_NONE;
      endcase
   end

   assign busy = state_ff != ST_IDLE;
   assign load = (state_ff == ST_DONE) && out_free;

endmodule
`default_nettype wire

>>> src/ate_datapath.sv
// Angle datapath: shared multiplier, bitwise square root, CORDIC, degree scaling.
`default_nettype none
module ate_datapath #(
   parameter int ANGLE_FRAC_BITS = 7
) (
   input  wire logic                  clock,
   input  wire ate_pkg::dp_cmd_type   cmd,
   input  wire ate_pkg::word_set_type words_in,
   output      ate_pkg::word_set_type words_out,
   output      logic [15:0]           roll_out,
   output      logic [14:0]           pitch_out
);

   localparam int CW    = ate_pkg::CORDIC_W;
   localparam int SHIFT = 54 - ANGLE_FRAC_BITS;
   localparam logic signed [63:0] ROUND_HALF = 64'sd1 <<< (SHIFT - 1);
   localparam logic signed [63:0] ROLL_LIM   = 64'(180 * (2 ** ANGLE_FRAC_BITS));
   localparam logic signed [63:0] PITCH_LIM  = 64'(90 * (2 ** ANGLE_FRAC_BITS));

   ate_pkg::word_set_type  word_ff;
   logic [31:0]            rad_ff;
   logic [17:0]            rem_ff;
   logic [15:0]            root_ff;
   logic signed [CW-1:0]   x_ff, y_ff, z_ff;
   logic signed [63:0]     acc_ff;
   logic [15:0]            roll_ff;
   logic [14:0]            pitch_ff;

   logic signed [15:0]     ax, ay, az;
   logic signed [18:0]     mul_a;
   logic signed [30:0]     mul_b;
   logic signed [49:0]     prod;
   logic [19:0]            rem_sh, trial;
   logic                   root_bit;
   logic signed [17:0]     cy, cx, y_pre, x_pre;
   logic signed [CW-1:0]   z_pre;
   logic signed [CW-1:0]   xs, ys, at;
   logic signed [63:0]     rsum, rsh, lim, rsat;

   assign ax = signed'(word_ff[ate_pkg::AX_IDX]);
   assign ay = signed'(word_ff[ate_pkg::AY_IDX]);
   assign az = signed'(word_ff[ate_pkg::AZ_IDX]);

   // one shared multiplier: squares, then the two halves of the degree product
   always_comb begin
      case (cmd.op)
         ate_pkg::OP_SQ_A: begin
            mul_a = 19'(ay);
            mul_b = 31'(ay);
         end
         ate_pkg::OP_SQ_B: begin
            mul_a = 19'(az);
            mul_b = 31'(az);
         end
         ate_pkg::OP_MUL_LO: begin
            mul_a = signed'({1'b0, z_ff[17:0]});
            mul_b = ate_pkg::DEG_PER_RAD;
         end
         ate_pkg::OP_MUL_HI: begin
            mul_a = 19'(signed'(z_ff[CW-1:18]));
            mul_b = ate_pkg::DEG_PER_RAD;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod = mul_a * mul_b;
   end

   // one result bit of the floor root per step
   always_comb begin
      rem_sh   = {rem_ff, rad_ff[31:30]};
      trial    = {2'b00, root_ff, 2'b01};
      root_bit = rem_sh >= trial;
   end

   // CORDIC start: fold a negative x by a half turn
   always_comb begin
      if (cmd.pitch_sel) begin
         cy = -(18'(ax));
         cx = signed'({2'b00, root_ff});
      end else begin
         cy = 18'(ay);
         cx = 18'(az);
      end
      if (cx[17]) begin
         x_pre = -cx;
         y_pre = -cy;
         z_pre = cy[17] ? -ate_pkg::PI_Q30 : ate_pkg::PI_Q30;
      end else begin
         x_pre = cx;
         y_pre = cy;
         z_pre = '0;
      end
      xs = x_ff >>> cmd.step;
      ys = y_ff >>> cmd.step;
      at = signed'(CW'(ate_pkg::atan_q30(cmd.step)));
   end

   // round half up, drop the fraction, clamp
   always_comb begin
      rsum = acc_ff + ROUND_HALF;
      rsh  = rsum >>> SHIFT;
      lim  = cmd.pitch_sel ? PITCH_LIM : ROLL_LIM;
      if (rsh > lim) begin
         rsat = lim;
      end else if (rsh < -lim) begin
         rsat = -lim;
      end else begin
         rsat = rsh;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         ate_pkg::OP_CAPTURE: word_ff <= words_in;
         ate_pkg::OP_SQ_A: begin
            rad_ff  <= prod[31:0];
            rem_ff  <= '0;
            root_ff <= '0;
         end
         ate_pkg::OP_SQ_B: rad_ff <= rad_ff + prod[31:0];
         ate_pkg::OP_SQRT: begin
            rad_ff  <= {rad_ff[29:0], 2'b00};
            rem_ff  <= 18'(root_bit ? rem_sh - trial : rem_sh);
            root_ff <= {root_ff[14:0], root_bit};
         end
         ate_pkg::OP_INIT: begin
            x_ff <= CW'(x_pre) <<< ate_pkg::PRESCALE;
            y_ff <= CW'(y_pre) <<< ate_pkg::PRESCALE;
            z_ff <= z_pre;
         end
         ate_pkg::OP_ITER: begin
            // hold once y reaches zero
            if (y_ff != '0) begin
               if (!y_ff[CW-1]) begin
                  x_ff <= x_ff + ys;
                  y_ff <= y_ff - xs;
                  z_ff <= z_ff + at;
               end else begin
                  x_ff <= x_ff - ys;
                  y_ff <= y_ff + xs;
                  z_ff <= z_ff - at;
               end
            end
         end
         ate_pkg::OP_MUL_LO: acc_ff <= 64'(prod);
         ate_pkg::OP_MUL_HI: acc_ff <= acc_ff + (64'(prod) <<< 18);
         ate_pkg::OP_ROUND: begin
            if (cmd.pitch_sel) begin
               pitch_ff <= rsat[14:0];
            end else begin
               roll_ff <= rsat[15:0];
            end
         end
         default: ;
      endcase
   end

   assign words_out = word_ff;
   assign roll_out  = roll_ff;
   assign pitch_out = pitch_ff;

endmodule
`default_nettype wire
